### rtl/lir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lir_pkg
// Shared constants and types of the linear interpolation resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

   localparam int MAX_PHASES  = 256;
   localparam int MAX_BURST   = 16;
   localparam int STEP_BITS   = 4;
   localparam int SAMPLE_W    = 16;
   localparam int WEIGHT_W    = 16;
   localparam int INDEX_W     = 8;
   localparam int PHASE_BITS  = $clog2(MAX_PHASES);
   localparam int PCOUNT_W    = 9;
   localparam int BURST_W     = $clog2(MAX_BURST + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int PROD_W      = SAMPLE_W + WEIGHT_W + 1;
   localparam int SUM_W       = PROD_W + 1;
   localparam int FRAC_BITS   = 15;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_TABLE  = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type                  kind;
      logic signed [SAMPLE_W-1:0]  sample;
      logic [INDEX_W-1:0]          index;
      logic [WEIGHT_W-1:0]         weight_cur;
      logic [WEIGHT_W-1:0]         weight_prev;
      logic [STEP_BITS-1:0]        step;
   } cmd_type;

endpackage

### rtl/lir_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lir_if
// Request and response channels of the resampler, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lir_req_if;
   logic               valid;
   logic               ready;
   logic               opcode;
   logic signed [15:0] in_sample;
   logic [7:0]         entry_index;
   logic [15:0]        weight_current;
   logic [15:0]        weight_previous;
   logic [3:0]         step;

   modport source (
      output valid, opcode, in_sample, entry_index, weight_current, weight_previous, step,
      input  ready
   );
   modport sink (
      input  valid, opcode, in_sample, entry_index, weight_current, weight_previous, step,
      output ready
   );
endinterface

interface lir_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] out_sample;
   logic               last;

   modport source (
      output valid, out_sample, last,
      input  ready
   );
   modport sink (
      input  valid, out_sample, last,
      output ready
   );
endinterface

### rtl/lir_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lir_front
// Input stage: accept request words, decode the opcode and hand commands on.
// ----------------------------------------------------------------------------
module lir_front
   import lir_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   lir_req_if.sink    req_ch,
   output logic       cmd_valid,
   input  logic       cmd_ready,
   output cmd_type    cmd
);

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    accept;

   assign req_ch.ready = !valid_ff || cmd_ready;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      cmd_in             = cmd_ff;
      valid_in           = valid_ff;
      if (cmd_ready) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in           = 1'b1;
         cmd_in.kind        = req_ch.opcode ? OP_TABLE : OP_SAMPLE;
         cmd_in.sample      = req_ch.in_sample;
         cmd_in.index       = req_ch.entry_index;
         cmd_in.weight_cur  = req_ch.weight_current;
         cmd_in.weight_prev = req_ch.weight_previous;
         cmd_in.step        = req_ch.step[STEP_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

endmodule

### rtl/lir_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lir_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module lir_queue
   import lir_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/lir_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lir_back
// Execution engine: phase tables, skip counting, weighted sum and output word.
// ----------------------------------------------------------------------------
module lir_back
   import lir_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [PCOUNT_W-1:0] csr_wr_data,
   input  logic                cmd_valid,
   output logic                cmd_ready,
   input  cmd_type             cmd,
   lir_rsp_if.source           rsp_ch
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_OUT
   } state_type;

   state_type                   state_ff;
   logic [PCOUNT_W-1:0]         pcount_ff, pcount_in;
   logic [PHASE_BITS-1:0]       phase_ff;
   logic [STEP_BITS-1:0]        skip_ff;
   logic signed [SAMPLE_W-1:0]  prev_ff;
   logic signed [SAMPLE_W-1:0]  cur_ff;
   logic [BURST_W-1:0]          burst_ff;
   logic [STEP_BITS-1:0]        step_ff;
   logic signed [PROD_W-1:0]    prod_p_ff, prod_c_ff;
   logic signed [SUM_W-1:0]     sum_ff;
   logic                        rsp_valid_ff;
   logic signed [SAMPLE_W-1:0]  rsp_sample_ff, rsp_sample_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic [2*WEIGHT_W-1:0]       wmem [MAX_PHASES];
   logic [STEP_BITS-1:0]        smem [MAX_PHASES];
   logic [2*WEIGHT_W-1:0]       wrd_ff;
   logic [STEP_BITS-1:0]        srd_ff;

   logic [PHASE_BITS-1:0]       phase_nxt;
   logic                        pop, tbl_wr, can_load, done;
   logic signed [SUM_W-1:0]     sum_adj;
   logic signed [SUM_W-FRAC_BITS-1:0] quot;
   logic [WEIGHT_W-1:0]         rd_wc, rd_wp;

   assign cmd_ready = (state_ff == ST_IDLE);
   assign pop       = cmd_valid && cmd_ready;
   assign tbl_wr    = pop && (cmd.kind == OP_TABLE);
   assign can_load  = !rsp_valid_ff || rsp_ch.ready;
   assign done      = (step_ff != '0) || (burst_ff >= BURST_W'(MAX_BURST));
   assign rd_wc     = wrd_ff[2*WEIGHT_W-1:WEIGHT_W];
   assign rd_wp     = wrd_ff[WEIGHT_W-1:0];

   always_comb begin
      if (({1'b0, phase_ff} + 1'b1) >= pcount_ff) begin
         phase_nxt = '0;
      end else begin
         phase_nxt = phase_ff + 1'b1;
      end
   end

   always_comb begin
      pcount_in = csr_wr_data;
      if (csr_wr_data == '0) begin
         pcount_in = PCOUNT_W'(1);
      end else if (csr_wr_data > PCOUNT_W'(MAX_PHASES)) begin
         pcount_in = PCOUNT_W'(MAX_PHASES);
      end
   end

   always_comb begin
      if (sum_ff < 0) begin
         sum_adj = sum_ff + SUM_W'((1 << FRAC_BITS) - 1);
      end else begin
         sum_adj = sum_ff;
      end
      quot = sum_adj[SUM_W-1:FRAC_BITS];
      if (quot > (SUM_W-FRAC_BITS)'(32767)) begin
         rsp_sample_in = 16'sh7fff;
      end else if (quot < -(SUM_W-FRAC_BITS)'(32768)) begin
         rsp_sample_in = -16'sh8000;
      end else begin
         rsp_sample_in = quot[SAMPLE_W-1:0];
      end
      rsp_last_in = done;
   end

   always_ff @(posedge clock) begin
      if (tbl_wr) begin
         wmem[cmd.index] <= {cmd.weight_cur, cmd.weight_prev};
         smem[cmd.index] <= cmd.step;
      end
      wrd_ff <= wmem[phase_ff];
      srd_ff <= smem[phase_nxt];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pcount_ff    <= PCOUNT_W'(1);
         phase_ff     <= '0;
         skip_ff      <= '0;
         prev_ff      <= '0;
         burst_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            pcount_ff <= pcount_in;
         end
         if (rsp_ch.ready && !((state_ff == ST_OUT) && can_load)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (pop && (cmd.kind == OP_SAMPLE)) begin
                  if (skip_ff != '0) begin
                     skip_ff <= skip_ff - 1'b1;
                     prev_ff <= cmd.sample;
                  end else begin
                     burst_ff <= '0;
                     state_ff <= ST_MUL;
                  end
               end
            end
            ST_MUL: begin
               phase_ff <= phase_nxt;
               step_ff  <= srd_ff;
               burst_ff <= burst_ff + 1'b1;
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (can_load) begin
                  rsp_valid_ff <= 1'b1;
                  if (done) begin
                     skip_ff  <= (step_ff == '0) ? '0 : step_ff - 1'b1;
                     prev_ff  <= cur_ff;
                     state_ff <= ST_IDLE;
                  end else begin
                     state_ff <= ST_MUL;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= cmd.sample;
      end
      if (state_ff == ST_MUL) begin
         prod_p_ff <= PROD_W'(prev_ff * $signed({1'b0, rd_wp}));
         prod_c_ff <= PROD_W'(cur_ff * $signed({1'b0, rd_wc}));
      end
      if (state_ff == ST_SUM) begin
         sum_ff <= SUM_W'(prod_p_ff) + SUM_W'(prod_c_ff);
      end
      if ((state_ff == ST_OUT) && can_load) begin
         rsp_sample_ff <= rsp_sample_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_sample = rsp_sample_ff;
   assign rsp_ch.last       = rsp_last_ff;

endmodule

### rtl/linear_interp_resampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_interp_resampler
// Rational-ratio linear interpolation resampler for signed 16-bit audio.
// ----------------------------------------------------------------------------
// Request words either load one phase table entry (two unsigned Q1.15
// weights and a step) or carry one audio sample. The front end registers and
// decodes each word into a four-entry queue; the back end executes from it.
// A table write or a skipped sample is taken in the idle state; each output
// word of a sample passes through table read, multiply, sum, then
// round-toward-zero, saturate and load the output register. The output
// register frees the back end as soon as the word is taken. Phase count is
// written on csr_wr_en (0 acts as 1, above 256 acts as 256); the user must
// write it only while the block is idle, which the block does not enforce.
// Table entries read before being written give undefined output values.
// ----------------------------------------------------------------------------
module linear_interp_resampler
   import lir_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [PCOUNT_W-1:0] csr_wr_data,
   lir_req_if.sink             req_ch,
   lir_rsp_if.source           rsp_ch
);

   logic    f_valid, f_ready;
   cmd_type f_cmd;
   logic    q_valid, q_ready;
   cmd_type q_cmd;

   lir_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cmd_valid (f_valid),
      .cmd_ready (f_ready),
      .cmd       (f_cmd)
   );

   lir_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_cmd   (f_cmd),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_cmd    (q_cmd)
   );

   lir_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd_valid   (q_valid),
      .cmd_ready   (q_ready),
      .cmd         (q_cmd),
      .rsp_ch      (rsp_ch)
   );

endmodule

### tb/tb_linear_interp_resampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_interp_resampler
// Self-checking bench for the linear interpolation resampler. A directed
// opening covers exact pass-through, truncation toward zero, saturation with
// oversized weights, the burst cap and skipped samples. Random traffic then
// runs under a series of phase counts, the extremes among them. Each accepted
// request word updates a cycle-free model of the resampler, which queues the
// output words it predicts. Every output word is checked against the oldest
// prediction. Both channels idle at random, and the output side also holds
// off once for a long stretch so that the request side backs up.
// ----------------------------------------------------------------------------
module tb_linear_interp_resampler
   import lir_pkg::*;
();

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] value;
      logic                       last_flag;
   } out_word_type;

   localparam int IDLE_PCT    = 15;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE      = 30;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [PCOUNT_W-1:0] csr_wr_data;

   lir_req_if req_ch ();
   lir_rsp_if rsp_ch ();

   linear_interp_resampler u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   // stimulus side
   cmd_type      req_words[$];
   bit           loaded[MAX_PHASES];
   bit           calm       = 1'b0;
   bit           hold_armed = 1'b0;
   logic         hold_taken;
   int           hold_left;
   logic signed [SAMPLE_W-1:0] sample_extremes[4] = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff};
   int           cfg_settings[8] = '{511, 3, 0, 2, 7, 300, 5, 1};

   // resampler model
   int                        n_phases = 1;
   logic signed [SAMPLE_W-1:0] prev_in = '0;
   logic [PHASE_BITS-1:0]     phase_now = '0;
   logic [STEP_BITS-1:0]      skips_left = '0;
   logic [WEIGHT_W-1:0]       wcur_table[MAX_PHASES];
   logic [WEIGHT_W-1:0]       wprev_table[MAX_PHASES];
   logic [STEP_BITS-1:0]      step_tbl[MAX_PHASES];
   out_word_type              expected_words[$];

   int errors         = 0;
   int n_samples      = 0;
   int n_table_writes = 0;
   int n_skipped      = 0;
   int n_capped       = 0;
   int n_checked      = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("timeout: %0d output words still expected", expected_words.size());
      $display("== FAIL ==");
      $finish;
   end

   function automatic logic [STEP_BITS-1:0] pick_step();
      int roll;
      roll = $urandom_range(99);
      if (roll < 35) begin
         return '0;
      end else if (roll < 80) begin
         return STEP_BITS'($urandom_range(3, 1));
      end
      return STEP_BITS'($urandom_range(15, 4));
   endfunction

   task automatic pick_weights(output logic [WEIGHT_W-1:0] wc, output logic [WEIGHT_W-1:0] wp);
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) begin
         wc = WEIGHT_W'($urandom_range(32768));
         wp = WEIGHT_W'(32768 - int'(wc));
      end else if (roll < 85) begin
         wc = $urandom_range(1) ? 16'h8000 : 16'h0000;
         wp = $urandom_range(1) ? 16'h8000 : 16'h0000;
      end else begin
         wc = WEIGHT_W'($urandom_range(65535));
         wp = WEIGHT_W'($urandom_range(65535));
      end
   endtask

   task automatic push_table(input logic [INDEX_W-1:0] idx, input logic [WEIGHT_W-1:0] wc,
                             input logic [WEIGHT_W-1:0] wp, input logic [STEP_BITS-1:0] st);
      cmd_type c;
      c             = '0;
      c.kind        = OP_TABLE;
      c.index       = idx;
      c.weight_cur  = wc;
      c.weight_prev = wp;
      c.step        = st;
      c.sample      = SAMPLE_W'($urandom_range(65535));
      loaded[idx]   = 1'b1;
      req_words.push_back(c);
   endtask

   task automatic push_sample(input logic signed [SAMPLE_W-1:0] s);
      cmd_type c;
      c        = '0;
      c.kind   = OP_SAMPLE;
      c.sample = s;
      c.index  = INDEX_W'($urandom_range(255));
      req_words.push_back(c);
   endtask

   task automatic push_random();
      int                  roll;
      int                  idx;
      logic [WEIGHT_W-1:0] wc;
      logic [WEIGHT_W-1:0] wp;
      roll = $urandom_range(99);
      if (roll < 20) begin
         idx = ($urandom_range(99) < 70) ? $urandom_range(n_phases - 1) : $urandom_range(255);
         pick_weights(wc, wp);
         push_table(INDEX_W'(idx), wc, wp, pick_step());
      end else if (roll < 28) begin
         push_sample(sample_extremes[$urandom_range(3)]);
      end else begin
         push_sample(SAMPLE_W'($urandom_range(65535)));
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (req_words.size() != 0 || req_ch.valid || expected_words.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic advance_model(input cmd_type c);
      longint                acc;
      int                    burst;
      int                    nxt;
      logic [STEP_BITS-1:0]  adv;
      out_word_type          w;
      if (c.kind == OP_TABLE) begin
         wcur_table[c.index]  = c.weight_cur;
         wprev_table[c.index] = c.weight_prev;
         step_tbl[c.index]    = c.step;
         n_table_writes++;
      end else if (skips_left != 0) begin
         skips_left--;
         prev_in = c.sample;
         n_skipped++;
         n_samples++;
      end else begin
         burst = 0;
         do begin
            acc = longint'(prev_in) * longint'(wprev_table[phase_now])
                + longint'(c.sample) * longint'(wcur_table[phase_now]);
            acc = acc / (longint'(1) << FRAC_BITS);
            if (acc > 32767) begin
               acc = 32767;
            end else if (acc < -32768) begin
               acc = -32768;
            end
            burst++;
            nxt = int'(phase_now) + 1;
            if (nxt >= n_phases) begin
               nxt = 0;
            end
            phase_now = PHASE_BITS'(nxt);
            adv = step_tbl[phase_now];
            if (adv == 0 && burst >= MAX_BURST) begin
               adv = STEP_BITS'(1);
            end
            w.value     = acc[SAMPLE_W-1:0];
            w.last_flag = (adv != 0);
            expected_words.push_back(w);
         end while (adv == 0);
         if (burst == MAX_BURST) begin
            n_capped++;
         end
         skips_left = adv - 1'b1;
         prev_in    = c.sample;
         n_samples++;
      end
   endtask

   // request driver
   always @(posedge clock) begin : drive_req
      cmd_type w;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_words.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
            w = req_words.pop_front();
            req_ch.valid           <= 1'b1;
            req_ch.opcode          <= w.kind;
            req_ch.in_sample       <= w.sample;
            req_ch.entry_index     <= w.index;
            req_ch.weight_current  <= w.weight_cur;
            req_ch.weight_previous <= w.weight_prev;
            req_ch.step            <= w.step;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // output receiver, with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= 0;
         hold_taken   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (hold_armed && !hold_taken) begin
         hold_taken   <= 1'b1;
         hold_left    <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // predict on accepted requests, check accepted output words
   always @(posedge clock) begin : watch
      cmd_type      c;
      out_word_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            c             = '0;
            c.kind        = opcode_type'(req_ch.opcode);
            c.sample      = req_ch.in_sample;
            c.index       = req_ch.entry_index;
            c.weight_cur  = req_ch.weight_current;
            c.weight_prev = req_ch.weight_previous;
            c.step        = req_ch.step;
            advance_model(c);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            n_checked++;
            if (expected_words.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("%0t: unexpected output word out_sample=%0d last=%0b",
                           $time, rsp_ch.out_sample, rsp_ch.last);
               end
            end else begin
               want = expected_words.pop_front();
               if (rsp_ch.out_sample !== want.value || rsp_ch.last !== want.last_flag) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%0t: mismatch out_sample exp %0d got %0d, last exp %0b got %0b",
                              $time, want.value, rsp_ch.out_sample, want.last_flag,
                              rsp_ch.last);
                  end
               end
            end
         end
      end
   end

   initial begin
      int pc;
      reset                  = 1'b1;
      csr_wr_en              = 1'b0;
      csr_wr_data            = '0;
      req_ch.valid           = 1'b0;
      req_ch.opcode          = 1'b0;
      req_ch.in_sample       = '0;
      req_ch.entry_index     = '0;
      req_ch.weight_current  = '0;
      req_ch.weight_previous = '0;
      req_ch.step            = '0;
      rsp_ch.ready           = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // pass-through, truncation, saturation, burst cap, skipping
      push_table(8'd0, 16'h8000, 16'h0000, 4'd1);
      push_sample(16'sh7fff);
      push_sample(16'sh8000);
      push_sample(16'sh0000);
      push_table(8'd0, 16'h4000, 16'h0000, 4'd1);
      push_sample(-16'sd3);
      push_sample(16'sd3);
      push_table(8'd0, 16'hffff, 16'hffff, 4'd1);
      push_sample(16'sh7fff);
      push_sample(16'sh8000);
      push_sample(16'sh8000);
      push_table(8'd0, 16'h0000, 16'h8000, 4'd0);
      push_sample(16'sd1234);
      push_table(8'd0, 16'h8000, 16'h0000, 4'd3);
      push_sample(16'sd100);
      push_sample(16'sd200);
      push_sample(16'sd300);
      push_sample(-16'sd400);
      push_table(8'd255, 16'hffff, 16'hffff, 4'd15);
      push_table(8'd0, 16'h4000, 16'h4000, 4'd1);
      push_sample(16'sh7fff);

      foreach (cfg_settings[k]) begin
         wait_idle();
         @(posedge clock);
         csr_wr_en   <= 1'b1;
         csr_wr_data <= PCOUNT_W'(cfg_settings[k]);
         @(posedge clock);
         csr_wr_en <= 1'b0;
         pc = cfg_settings[k];
         if (pc == 0) begin
            pc = 1;
         end else if (pc > MAX_PHASES) begin
            pc = MAX_PHASES;
         end
         n_phases = pc;
         calm = (k == 3);
         if (k == 2) begin
            hold_armed = 1'b1;
         end
         for (int i = 0; i < pc; i++) begin
            if (!loaded[i] || i < 32) begin
               logic [WEIGHT_W-1:0] wc;
               logic [WEIGHT_W-1:0] wp;
               pick_weights(wc, wp);
               push_table(INDEX_W'(i), wc, wp, pick_step());
            end
         end
         repeat (10) push_random();
      end

      wait_idle();
      $display("Ran %0d samples (%0d skipped) and %0d table writes over %0d phase counts",
               n_samples, n_skipped, n_table_writes, $size(cfg_settings) + 1);
      $display("Checked %0d output words, %0d bursts at the cap length, %0d errors",
               n_checked, n_capped, errors);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### files.f
rtl/lir_pkg.sv
rtl/lir_if.sv
rtl/lir_front.sv
rtl/lir_queue.sv
rtl/lir_back.sv
rtl/linear_interp_resampler.sv
tb/tb_linear_interp_resampler.sv
